>>> rtl/ifgc_pkg.sv
// ----------------------------------------------------------------------------
// ifgc_pkg
// Shared types, constants and the verdict function for the fragment group
// checker.
// ----------------------------------------------------------------------------
`default_nettype none

package ifgc_pkg;

	localparam int ADDR_W    = 32;
	localparam int IDENT_W   = 16;
	localparam int OFFS_W    = 13;
	localparam int PAY_W     = 16;
	localparam int NEXT_W    = 14;
	localparam int MARKS_W   = 2;

	localparam logic [PAY_W-1:0]   PAYLOAD_MAX = '1;
	localparam logic [NEXT_W-1:0]  OFFSET_MAX  = '1;
	localparam logic [MARKS_W-1:0] MARKS_MAX   = '1;

	// result queue geometry
	localparam int QUEUE_DEPTH = 3;
	localparam int QPTR_W      = 2;

	typedef enum logic [1:0] {
		VERDICT_COMPLETE  = 2'd0,
		VERDICT_DUP_LAST  = 2'd1,
		VERDICT_MISS_LAST = 2'd2,
		VERDICT_OFFS_BAD  = 2'd3
	} verdict_t;

	typedef struct packed {
		logic [ADDR_W-1:0]  address;
		logic [IDENT_W-1:0] ident;
		verdict_t           verdict;
		logic [PAY_W-1:0]   total;
		logic               run_last;
	} result_t;

	// up to two results caused by one request, res0 goes out first
	typedef struct packed {
		logic    push0;
		logic    push1;
		result_t res0;
		result_t res1;
	} push_t;

	// verdict priority: duplicate last, missing last, offset mismatch
	function automatic verdict_t verdict_of(logic [MARKS_W-1:0] marks, logic bad);
		verdict_t v;
		if (marks > MARKS_W'(1)) begin
			v = VERDICT_DUP_LAST;
		end else if (marks == '0) begin
			v = VERDICT_MISS_LAST;
		end else if (bad) begin
			v = VERDICT_OFFS_BAD;
		end else begin
			v = VERDICT_COMPLETE;
		end
		return v;
	endfunction

endpackage

`default_nettype wire

>>> rtl/ifgc_group_core.sv
// ----------------------------------------------------------------------------
// ifgc_group_core
// Holds the open fragment group and its running totals; on each accepted
// request it updates them and forms up to two verdicts.
// ----------------------------------------------------------------------------
`default_nettype none

module ifgc_group_core (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            accept,
	input  wire logic [ifgc_pkg::ADDR_W-1:0]     source_address,
	input  wire logic [ifgc_pkg::IDENT_W-1:0]    fragment_ident,
	input  wire logic [ifgc_pkg::OFFS_W-1:0]     frag_offset,
	input  wire logic                            more_frags,
	input  wire logic [ifgc_pkg::PAY_W-1:0]      payload_bytes,
	input  wire logic                            stream_end,
	output ifgc_pkg::push_t                      push
);

	logic                            group_valid_q;
	logic [ifgc_pkg::ADDR_W-1:0]     held_address_q;
	logic [ifgc_pkg::IDENT_W-1:0]    held_ident_q;
	logic [ifgc_pkg::PAY_W-1:0]      payload_sum_q;
	logic [ifgc_pkg::NEXT_W-1:0]     next_offset_q;
	logic [ifgc_pkg::MARKS_W-1:0]    last_marks_q;
	logic                            offset_bad_q;

	logic                            key_diff;
	logic                            emit_old;
	logic                            new_group;
	logic [ifgc_pkg::PAY_W-1:0]      base_sum;
	logic [ifgc_pkg::NEXT_W-1:0]     base_off;
	logic [ifgc_pkg::MARKS_W-1:0]    base_marks;
	logic                            base_bad;
	logic [ifgc_pkg::PAY_W:0]        sum_wide;
	logic [ifgc_pkg::NEXT_W:0]       off_wide;
	logic [ifgc_pkg::PAY_W-1:0]      sum_upd;
	logic [ifgc_pkg::NEXT_W-1:0]     off_upd;
	logic [ifgc_pkg::MARKS_W-1:0]    marks_upd;
	logic                            bad_upd;
	ifgc_pkg::result_t               old_res;
	ifgc_pkg::result_t               new_res;

	// group boundary detection
	assign key_diff  = (source_address != held_address_q) || (fragment_ident != held_ident_q);
	assign emit_old  = group_valid_q && key_diff;
	assign new_group = !group_valid_q || key_diff;

	// start values: fresh group or the running totals
	assign base_sum   = new_group ? '0 : payload_sum_q;
	assign base_off   = new_group ? '0 : next_offset_q;
	assign base_marks = new_group ? '0 : last_marks_q;
	assign base_bad   = new_group ? 1'b0 : offset_bad_q;

	// saturating updates
	assign sum_wide = {1'b0, base_sum} + {1'b0, payload_bytes};
	assign off_wide = {1'b0, base_off} + (ifgc_pkg::NEXT_W+1)'(payload_bytes[ifgc_pkg::PAY_W-1:3]);
	assign sum_upd  = sum_wide[ifgc_pkg::PAY_W] ? ifgc_pkg::PAYLOAD_MAX
	                                            : sum_wide[ifgc_pkg::PAY_W-1:0];
	assign off_upd  = off_wide[ifgc_pkg::NEXT_W] ? ifgc_pkg::OFFSET_MAX
	                                             : off_wide[ifgc_pkg::NEXT_W-1:0];
	assign marks_upd = (!more_frags && (base_marks != ifgc_pkg::MARKS_MAX))
	                   ? base_marks + ifgc_pkg::MARKS_W'(1) : base_marks;
	assign bad_upd   = base_bad || ({1'b0, frag_offset} != base_off);

	// verdicts for the closing group and for the flushed group
	always_comb begin
		old_res.address  = held_address_q;
		old_res.ident    = held_ident_q;
		old_res.verdict  = ifgc_pkg::verdict_of(last_marks_q, offset_bad_q);
		old_res.total    = payload_sum_q;
		old_res.run_last = !stream_end;

		new_res.address  = source_address;
		new_res.ident    = fragment_ident;
		new_res.verdict  = ifgc_pkg::verdict_of(marks_upd, bad_upd);
		new_res.total    = sum_upd;
		new_res.run_last = 1'b1;
	end

	// results handed to the queue
	always_comb begin
		push.push0 = accept && (emit_old || stream_end);
		push.push1 = accept && emit_old && stream_end;
		push.res0  = emit_old ? old_res : new_res;
		push.res1  = new_res;
	end

	// group state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			group_valid_q  <= 1'b0;
			held_address_q <= '0;
			held_ident_q   <= '0;
			payload_sum_q  <= '0;
			next_offset_q  <= '0;
			last_marks_q   <= '0;
			offset_bad_q   <= 1'b0;
		end else if (accept) begin
			group_valid_q  <= !stream_end;
			held_address_q <= source_address;
			held_ident_q   <= fragment_ident;
			payload_sum_q  <= sum_upd;
			next_offset_q  <= off_upd;
			last_marks_q   <= marks_upd;
			offset_bad_q   <= bad_upd;
		end
	end

endmodule

`default_nettype wire

>>> rtl/ifgc_result_queue.sv
// ----------------------------------------------------------------------------
// ifgc_result_queue
// Small register queue for verdicts: takes up to two per cycle, hands out
// one per cycle while pop is high.
// ----------------------------------------------------------------------------
`default_nettype none

module ifgc_result_queue (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire ifgc_pkg::push_t                 push,
	input  wire logic                            pop,
	output ifgc_pkg::result_t                    head,
	output logic                                 not_empty,
	output logic [ifgc_pkg::QPTR_W-1:0]          count
);

	ifgc_pkg::result_t                 entries_q [ifgc_pkg::QUEUE_DEPTH];
	logic [ifgc_pkg::QPTR_W-1:0]       wr_ptr_q;
	logic [ifgc_pkg::QPTR_W-1:0]       rd_ptr_q;
	logic [ifgc_pkg::QPTR_W-1:0]       count_q;
	logic [ifgc_pkg::QPTR_W-1:0]       wr_ptr_1;
	logic [ifgc_pkg::QPTR_W-1:0]       wr_ptr_2;
	logic [ifgc_pkg::QPTR_W-1:0]       rd_ptr_1;
	logic [ifgc_pkg::QPTR_W-1:0]       n_push;

	function automatic logic [ifgc_pkg::QPTR_W-1:0] ptr_inc(logic [ifgc_pkg::QPTR_W-1:0] p);
		logic [ifgc_pkg::QPTR_W-1:0] r;
		if (p == ifgc_pkg::QPTR_W'(ifgc_pkg::QUEUE_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + ifgc_pkg::QPTR_W'(1);
		end
		return r;
	endfunction

	assign wr_ptr_1 = ptr_inc(wr_ptr_q);
	assign wr_ptr_2 = ptr_inc(wr_ptr_1);
	assign rd_ptr_1 = ptr_inc(rd_ptr_q);
	assign n_push   = ifgc_pkg::QPTR_W'(push.push0) + ifgc_pkg::QPTR_W'(push.push1);

	assign head      = entries_q[rd_ptr_q];
	assign not_empty = (count_q != '0);
	assign count     = count_q;

	// entry storage
	always_ff @(posedge clk) begin
		for (int i = 0; i < ifgc_pkg::QUEUE_DEPTH; i++) begin
			if (push.push0 && (wr_ptr_q == ifgc_pkg::QPTR_W'(i))) begin
				entries_q[i] <= push.res0;
			end else if (push.push1 && (wr_ptr_1 == ifgc_pkg::QPTR_W'(i))) begin
				entries_q[i] <= push.res1;
			end
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push.push1) begin
				wr_ptr_q <= wr_ptr_2;
			end else if (push.push0) begin
				wr_ptr_q <= wr_ptr_1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_1;
			end
			count_q <= count_q + n_push - ifgc_pkg::QPTR_W'(pop);
		end
	end

endmodule

`default_nettype wire

>>> rtl/ip_fragment_group_checker_top.sv
// ----------------------------------------------------------------------------
// ip_fragment_group_checker_top
// Checks grouped IPv4 fragment descriptors and emits one verdict per
// fragment group.
//
//   channel  handshake          payload
//   in       in_valid/in_stall   source_address fragment_ident frag_offset
//                                more_frags payload_bytes stream_end
//   out      out_valid/out_stall group_address group_ident verdict
//                                total_payload run_last
//
// One request is taken per cycle while in_stall is low; its verdicts enter a
// three-entry result queue at the same edge and are visible the next cycle.
// A request that closes one group and flushes another yields two verdicts;
// the queue drains one per cycle while out_stall is low, so input may stall.
// in_stall is high while the queue holds two or more verdicts.
// Reset clears the open group and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

module ip_fragment_group_checker_top (
	input  wire logic                            clk,
	input  wire logic                            arst_n,

	input  wire logic                            in_valid,
	output logic                                 in_stall,
	input  wire logic [ifgc_pkg::ADDR_W-1:0]     source_address,
	input  wire logic [ifgc_pkg::IDENT_W-1:0]    fragment_ident,
	input  wire logic [ifgc_pkg::OFFS_W-1:0]     frag_offset,
	input  wire logic                            more_frags,
	input  wire logic [ifgc_pkg::PAY_W-1:0]      payload_bytes,
	input  wire logic                            stream_end,

	output logic                                 out_valid,
	input  wire logic                            out_stall,
	output logic [ifgc_pkg::ADDR_W-1:0]          group_address,
	output logic [ifgc_pkg::IDENT_W-1:0]         group_ident,
	output logic [1:0]                           verdict,
	output logic [ifgc_pkg::PAY_W-1:0]           total_payload,
	output logic                                 run_last
);

	logic                            in_accept;
	logic                            out_pop;
	ifgc_pkg::push_t                 core_push;
	ifgc_pkg::result_t               head;
	logic [ifgc_pkg::QPTR_W-1:0]     q_count;

	// room for two verdicts is needed before a request is taken
	assign in_stall  = (q_count > ifgc_pkg::QPTR_W'(ifgc_pkg::QUEUE_DEPTH - 2));
	assign in_accept = in_valid && !in_stall;
	assign out_pop   = out_valid && !out_stall;

	ifgc_group_core u_core (
		.clk            (clk),
		.arst_n         (arst_n),
		.accept         (in_accept),
		.source_address (source_address),
		.fragment_ident (fragment_ident),
		.frag_offset    (frag_offset),
		.more_frags     (more_frags),
		.payload_bytes  (payload_bytes),
		.stream_end     (stream_end),
		.push           (core_push)
	);

	ifgc_result_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (core_push),
		.pop       (out_pop),
		.head      (head),
		.not_empty (out_valid),
		.count     (q_count)
	);

	// result fields
	assign group_address = head.address;
	assign group_ident   = head.ident;
	assign verdict       = head.verdict;
	assign total_payload = head.total;
	assign run_last      = head.run_last;

	// a flushing request always yields a verdict
	assert property (@(posedge clk) disable iff (!arst_n)
		in_accept && stream_end |-> core_push.push0)
		else $error("flush request produced no verdict");

	// a second verdict only comes with a flush
	assert property (@(posedge clk) disable iff (!arst_n)
		core_push.push1 |-> in_accept && stream_end && core_push.push0)
		else $error("second verdict without a flush");

	// of a verdict pair only the second closes the run
	assert property (@(posedge clk) disable iff (!arst_n)
		core_push.push1 |-> core_push.res1.run_last && !core_push.res0.run_last)
		else $error("run_last misplaced in verdict pair");

	// queue never overfills
	assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= ifgc_pkg::QPTR_W'(ifgc_pkg::QUEUE_DEPTH))
		else $error("result queue overflow");

endmodule

`default_nettype wire
